// File: rtl/rnta_pkg.sv
// shared types and constants of the road nearest track assign block
package rnta_pkg;

  localparam int MAX_TRACKS = 256;
  localparam int IDX_W      = $clog2(MAX_TRACKS);
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
  localparam int POS_W      = 20;
  localparam int DIFF_W     = POS_W + 1;
  localparam int SQ_W       = 2 * POS_W + 1;
  localparam int DIST_W     = SQ_W + 1;
  localparam int LIM_W      = 44;
  localparam int TRK_W      = 8;
  localparam logic [LIM_W-1:0] ROAD_LIMIT_RST = LIM_W'(6400);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } rnta_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_en;
    logic commit;
  } rnta_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } rnta_sts_t;

  // low bits of a candidate index, zero padded to the result width
  function automatic logic [TRK_W-1:0] to_track_index(logic [IDX_W-1:0] idx);
    logic [TRK_W-1:0] res;
    res = '0;
    for (int b = 0; b < TRK_W; b++) begin
      if (b < IDX_W) begin
        res[b] = idx[b];
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/rnta_hit_if.sv
// hit request channel
interface rnta_hit_if
  import rnta_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] hit_y;
  logic signed [POS_W-1:0] hit_z;
  logic                    event_start;

  modport source (output valid, hit_y, hit_z, event_start, input ready);
  modport sink   (input valid, hit_y, hit_z, event_start, output ready);
endinterface

// File: rtl/rnta_res_if.sv
// result request channel
interface rnta_res_if
  import rnta_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [TRK_W-1:0] track_index;
  logic             opened_track;
  logic             table_full;

  modport source (output valid, track_index, opened_track, table_full, input ready);
  modport sink   (input valid, track_index, opened_track, table_full, output ready);
endinterface

// File: rtl/rnta_ram.sv
// generic single write port ram with registered read
module rnta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/rnta_ctrl.sv
// sequencer for accept, candidate scan and commit
module rnta_ctrl
  import rnta_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rnta_sts_t sts_i,
  output rnta_cmd_t cmd_o
);
  rnta_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = !sts_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end
endmodule

// File: rtl/rnta_datapath.sv
// hit registers, track table, distance pipeline, best tracking and result register
module rnta_datapath
  import rnta_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rnta_cmd_t               cmd_i,
  output rnta_sts_t               sts_o,
  input  logic                    cfg_we_i,
  input  logic [LIM_W-1:0]        cfg_wdata_i,
  input  logic signed [POS_W-1:0] hit_y_i,
  input  logic signed [POS_W-1:0] hit_z_i,
  input  logic                    event_start_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [TRK_W-1:0]        track_index_o,
  output logic                    opened_track_o,
  output logic                    table_full_o
);
  logic [LIM_W-1:0]        road_limit_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        ptr_q, ptr_d;
  logic                    v1_q, v2_q, found_q, out_valid_q;
  logic                    v1_d, v2_d, found_d, out_valid_d;
  logic [IDX_W-1:0]        idx1_q, idx2_q, ibest_q, ibest_d;
  logic [DIST_W-1:0]       best_q, best_d;
  logic signed [POS_W-1:0] hy_q, hz_q;
  logic [SQ_W-1:0]         sq_y_q, sq_z_q;
  logic [TRK_W-1:0]        trk_q;
  logic                    opened_q, full_q;

  logic                    issue;
  logic [2*POS_W-1:0]      rd_data;
  logic signed [POS_W-1:0] mem_y, mem_z;
  logic signed [DIFF_W-1:0] dy, dz;
  logic signed [2*DIFF_W-1:0] prod_y, prod_z;
  logic [DIST_W-1:0]       dist_sum;
  logic                    need_new, full;
  logic [IDX_W-1:0]        widx;

  // read one table entry per cycle
  assign issue = cmd_i.scan_en && (ptr_q < count_q);

  rnta_ram #(
    .WIDTH (2 * POS_W),
    .DEPTH (MAX_TRACKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && !full),
    .waddr_i (widx),
    .wdata_i ({hy_q, hz_q}),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  assign mem_y    = rd_data[2*POS_W-1:POS_W];
  assign mem_z    = rd_data[POS_W-1:0];
  assign dy       = DIFF_W'(hy_q) - DIFF_W'(mem_y);
  assign dz       = DIFF_W'(hz_q) - DIFF_W'(mem_z);
  assign prod_y   = dy * dy;
  assign prod_z   = dz * dz;
  assign dist_sum = DIST_W'(sq_y_q) + DIST_W'(sq_z_q);

  // decision on the settled best candidate
  assign need_new = !found_q || (LIM_W'(best_q) > road_limit_q);
  assign full     = need_new && (count_q == CNT_W'(MAX_TRACKS));
  assign widx     = need_new ? count_q[IDX_W-1:0] : ibest_q;

  always_comb begin
    ptr_d   = ptr_q;
    count_d = count_q;
    found_d = found_q;
    best_d  = best_q;
    ibest_d = ibest_q;
    v1_d    = issue;
    v2_d    = v1_q;
    if (cmd_i.load) begin
      ptr_d   = '0;
      found_d = 1'b0;
      if (event_start_i) begin
        count_d = '0;
      end
    end else if (issue) begin
      ptr_d = ptr_q + CNT_W'(1);
    end
    // strict less keeps the lowest index on a tie
    if (v2_q && (!found_q || dist_sum < best_q)) begin
      found_d = 1'b1;
      best_d  = dist_sum;
      ibest_d = idx2_q;
    end
    if (cmd_i.commit && need_new && !full) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      road_limit_q <= ROAD_LIMIT_RST;
      count_q      <= '0;
      ptr_q        <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        road_limit_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hy_q <= hit_y_i;
      hz_q <= hit_z_i;
    end
    idx1_q  <= ptr_q[IDX_W-1:0];
    idx2_q  <= idx1_q;
    sq_y_q  <= prod_y[SQ_W-1:0];
    sq_z_q  <= prod_z[SQ_W-1:0];
    best_q  <= best_d;
    ibest_q <= ibest_d;
    if (cmd_i.commit) begin
      trk_q    <= full ? '0 : to_track_index(widx);
      opened_q <= need_new && !full;
      full_q   <= full;
    end
  end

  assign sts_o.scan_done = cmd_i.scan_en && !issue && !v1_q && !v2_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign track_index_o  = trk_q;
  assign opened_track_o = opened_q;
  assign table_full_o   = full_q;
endmodule

// File: rtl/road_nearest_track_assign.sv
// top level of the nearest neighbour road following track assigner
//
// usage
//   hit_i carries one detector hit per request (y, z, event_start); hits must
//   come in x order. res_o returns one request per hit: the track index, a
//   flag for a newly opened track and a flag for a full table.
//   cfg_we_i/cfg_wdata_i load the squared road limit; write only while idle.
// sequence
//   a hit is taken in the idle state, then every open candidate is read from
//   the track table at one entry per cycle; the read, square and compare
//   stages follow in that order, each registered, and the commit writes the
//   hit into the table as a new track or over the nearest one unless the
//   table is full. the result is registered at the commit, and the next hit
//   can be taken in the same cycle that the result shows.
// reset
//   clears the open track count and loads the road limit with 6400; the
//   table contents are not cleared, only entries below the count are read.
// back pressure
//   the result sits in an output register; a new hit is taken while it
//   waits, and the block holds in its commit cycle until the slot frees.
module road_nearest_track_assign
  import rnta_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  rnta_hit_if.sink         hit_i,
  rnta_res_if.source       res_o,
  input  logic             cfg_we_i,
  input  logic [LIM_W-1:0] cfg_wdata_i
);
  rnta_cmd_t cmd;
  rnta_sts_t sts;

  // sequencer: idle, scan, commit
  rnta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (hit_i.valid),
    .in_ready_o (hit_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // track table, distance pipeline and result register
  rnta_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .hit_y_i        (hit_i.hit_y),
    .hit_z_i        (hit_i.hit_z),
    .event_start_i  (hit_i.event_start),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .track_index_o  (res_o.track_index),
    .opened_track_o (res_o.opened_track),
    .table_full_o   (res_o.table_full)
  );

  // a commit never overwrites a result that is still waiting
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(res_o.valid && !res_o.ready))
    else $error("commit while result slot busy");

  // one hit at a time: no accept right after an accept
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_i.valid && hit_i.ready) |=> !hit_i.ready)
    else $error("hit accepted during scan");

  // a full table never reports an opened track
  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.table_full && res_o.opened_track))
    else $error("full and opened both set");

  // every commit produces a valid result at the next edge
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> res_o.valid)
    else $error("result missing after commit");
endmodule
